>>> design/isa_pkg.sv
package isa_pkg;

    // Field widths fixed by the request and result word formats
    localparam int OpW    = 4;
    localparam int PosW   = 7;
    localparam int WordW  = 32;
    localparam int StatW  = 2;
    localparam int CountW = 7;

    // Request opcodes; codes above OP_CLEAR are ignored and answer with a miss
    typedef enum logic [OpW-1:0] {
        OP_APPEND   = 4'd0,
        OP_PREPEND  = 4'd1,
        OP_POP_TAIL = 4'd2,
        OP_POP_HEAD = 4'd3,
        OP_INSERT   = 4'd4,
        OP_REMOVE   = 4'd5,
        OP_READ     = 4'd6,
        OP_WRITE    = 4'd7,
        OP_CLEAR    = 4'd8
    } t_opcode;

    // Result status codes
    typedef enum logic [StatW-1:0] {
        STAT_WORD = 2'd0,
        STAT_DONE = 2'd1,
        STAT_MISS = 2'd2,
        STAT_FULL = 2'd3
    } t_status;

    // What the sequencer has to do for one request
    typedef enum logic [2:0] {
        K_NOW,       // answer at once, nothing changes
        K_CLEAR,     // drop all words
        K_PUT_TAIL,  // store at index fill
        K_READ,      // read one slot
        K_WRITE_IN,  // read one slot, then overwrite it
        K_INSERT,    // shift the tail right, then store
        K_REMOVE     // take one slot, shift the tail left
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_status status;
    } t_plan;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHR,
        S_PUT,
        S_SHL
    } t_state;

    typedef struct packed {
        logic [OpW-1:0]   opcode;
        logic [PosW-1:0]  position;
        logic [WordW-1:0] value;
    } t_req;

    typedef struct packed {
        logic [StatW-1:0]  status;
        logic [WordW-1:0]  word_out;
        logic [CountW-1:0] held_count;
    } t_rsp;

endpackage

>>> design/isa_decode.sv
module isa_decode #(
    parameter int CAPACITY = 64
) (
    input  isa_pkg::t_req                       i_req,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_fill,
    output isa_pkg::t_plan                      o_plan,
    output logic [$clog2(CAPACITY)-1:0]         o_at
);
    import isa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > PosW) ? CW : PosW;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] fill_x;
    logic          full;
    logic          empty;
    logic [AW-1:0] pos_a;
    logic [AW-1:0] last_a;

    // Common compare width for position against fill
    assign pos_x  = XW'(i_req.position);
    assign fill_x = XW'(i_fill);
    assign full   = (fill_x == XW'(CAPACITY));
    assign empty  = (i_fill == '0);
    assign pos_a  = pos_x[AW-1:0];
    assign last_a = AW'(i_fill - CW'(1));

    // Classify the request; range check before full check
    always_comb begin
        o_plan.kind   = K_NOW;
        o_plan.status = STAT_MISS;
        o_at          = pos_a;
        case (i_req.opcode)
            OP_APPEND: begin
                if (full) begin
                    o_plan.status = STAT_FULL;
                end else begin
                    o_plan.kind = K_PUT_TAIL;
                end
            end
            OP_PREPEND: begin
                o_at = '0;
                if (full) begin
                    o_plan.status = STAT_FULL;
                end else if (empty) begin
                    o_plan.kind = K_PUT_TAIL;
                end else begin
                    o_plan.kind = K_INSERT;
                end
            end
            OP_POP_TAIL: begin
                o_at = last_a;
                if (!empty) begin
                    o_plan.kind = K_REMOVE;
                end
            end
            OP_POP_HEAD: begin
                o_at = '0;
                if (!empty) begin
                    o_plan.kind = K_REMOVE;
                end
            end
            OP_INSERT: begin
                if (pos_x > fill_x) begin
                    o_plan.status = STAT_MISS;
                end else if (full) begin
                    o_plan.status = STAT_FULL;
                end else if (pos_x == fill_x) begin
                    o_plan.kind = K_PUT_TAIL;
                end else begin
                    o_plan.kind = K_INSERT;
                end
            end
            OP_REMOVE: begin
                if (pos_x < fill_x) begin
                    o_plan.kind = K_REMOVE;
                end
            end
            OP_READ: begin
                if (pos_x < fill_x) begin
                    o_plan.kind = K_READ;
                end
            end
            OP_WRITE: begin
                if (pos_x < fill_x) begin
                    o_plan.kind = K_WRITE_IN;
                end else if (pos_x == fill_x) begin
                    if (full) begin
                        o_plan.status = STAT_FULL;
                    end else begin
                        o_plan.kind = K_PUT_TAIL;
                    end
                end
            end
            OP_CLEAR: begin
                o_plan.kind = K_CLEAR;
            end
            default: begin
                o_plan.kind   = K_NOW;
                o_plan.status = STAT_MISS;
            end
        endcase
    end

endmodule

>>> design/isa_seq.sv
module isa_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  isa_pkg::t_plan                    i_plan,
    input  logic [$clog2(CAPACITY)-1:0]       i_at,
    input  logic [isa_pkg::WordW-1:0]         i_value,
    output logic [$clog2(CAPACITY+1)-1:0]     o_fill,
    output logic                              o_busy,
    output logic                              o_fin,
    output isa_pkg::t_rsp                     o_rsp
);
    import isa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > CountW) ? CW : CountW;

    // Word store: one write port, one registered read port
    logic [WordW-1:0] r_slots [CAPACITY];
    logic [WordW-1:0] r_rdata;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_at, n_at;
    logic [AW-1:0]    r_last, n_last;
    logic [WordW-1:0] r_val, n_val;
    logic [WordW-1:0] r_word, n_word;
    logic             r_wr, n_wr;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [WordW-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [XW-1:0]    cnt_x;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_slots[waddr] <= wdata;
        end
        r_rdata <= r_slots[raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_at   <= n_at;
        r_last <= n_last;
        r_val  <= n_val;
        r_word <= n_word;
        r_wr   <= n_wr;
    end

    assign cnt_x = XW'(n_fill);

    // Sequencer: the index counter walks one slot per cycle
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_at    = r_at;
        n_last  = r_last;
        n_val   = r_val;
        n_word  = r_word;
        n_wr    = r_wr;
        we      = 1'b0;
        waddr   = r_at;
        wdata   = r_val;
        raddr   = r_idx;
        o_fin   = 1'b0;
        o_rsp.status   = STAT_DONE;
        o_rsp.word_out = '0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_at   = i_at;
                    n_val  = i_value;
                    n_last = AW'(r_fill - CW'(1));
                    case (i_plan.kind)
                        K_NOW: begin
                            o_fin        = 1'b1;
                            o_rsp.status = i_plan.status;
                        end
                        K_CLEAR: begin
                            n_fill = '0;
                            o_fin  = 1'b1;
                        end
                        K_PUT_TAIL: begin
                            we     = 1'b1;
                            waddr  = AW'(r_fill);
                            wdata  = i_value;
                            n_fill = r_fill + CW'(1);
                            o_fin  = 1'b1;
                        end
                        K_READ, K_WRITE_IN: begin
                            raddr   = i_at;
                            n_wr    = (i_plan.kind == K_WRITE_IN);
                            n_state = S_READ;
                        end
                        K_INSERT: begin
                            raddr   = AW'(r_fill - CW'(1));
                            n_idx   = AW'(r_fill - CW'(1));
                            n_state = S_SHR;
                        end
                        K_REMOVE: begin
                            raddr   = i_at;
                            n_idx   = i_at;
                            n_state = S_SHL;
                        end
                        default: begin
                            o_fin        = 1'b1;
                            o_rsp.status = STAT_MISS;
                        end
                    endcase
                end
            end
            S_READ: begin
                we             = r_wr;
                waddr          = r_at;
                wdata          = r_val;
                o_fin          = 1'b1;
                o_rsp.status   = STAT_WORD;
                o_rsp.word_out = r_rdata;
                n_state        = S_IDLE;
            end
            S_SHR: begin
                // Move slot idx up by one, walking down toward the insert point
                we    = 1'b1;
                waddr = r_idx + AW'(1);
                wdata = r_rdata;
                if (r_idx == r_at) begin
                    n_state = S_PUT;
                end else begin
                    raddr = r_idx - AW'(1);
                    n_idx = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                we      = 1'b1;
                waddr   = r_at;
                wdata   = r_val;
                n_fill  = r_fill + CW'(1);
                o_fin   = 1'b1;
                n_state = S_IDLE;
            end
            S_SHL: begin
                // First slot is the taken word; later slots move down by one
                if (r_idx == r_at) begin
                    n_word = r_rdata;
                end else begin
                    we    = 1'b1;
                    waddr = r_idx - AW'(1);
                    wdata = r_rdata;
                end
                if (r_idx == r_last) begin
                    n_fill         = r_fill - CW'(1);
                    o_fin          = 1'b1;
                    o_rsp.status   = STAT_WORD;
                    o_rsp.word_out = (r_idx == r_at) ? r_rdata : r_word;
                    n_state        = S_IDLE;
                end else begin
                    raddr = r_idx + AW'(1);
                    n_idx = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_rsp.held_count = cnt_x[CountW-1:0];
    end

    assign o_fill = r_fill;
    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/indexed_shift_array.sv
// Ordered word array of up to CAPACITY words kept packed from index 0, held in
// a RAM with one write port and one registered read port. A request is taken
// when start is high and busy is low; its result shows on o_rsp for one cycle
// with o_done, and there is no way to hold it off. Append, prepend to an empty
// array, insert or write at the tail, clear and any refused or missed request
// finish in the cycle they are taken (busy stays low, result in the next cycle).
// Read and in-place write pass a read state; pop tail is a remove at the last
// word. Insert at p below fill shifts words fill-1 down to p up one, then stores;
// remove at p takes that word and shifts the rest down one (pop head and
// prepend to non-empty use p = 0); the RAM read and write ports move one word per cycle.
module indexed_shift_array #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  isa_pkg::t_req  i_req,
    output logic           o_done,
    output isa_pkg::t_rsp  o_rsp
);
    import isa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_plan         plan;
    logic [AW-1:0] at;
    logic [CW-1:0] fill;
    logic          seq_busy;
    logic          go;
    logic          fin;
    t_rsp          fin_rsp;
    logic          r_done;
    t_rsp          r_rsp;

    assign go = start && !seq_busy;

    isa_decode #(.CAPACITY(CAPACITY)) u_decode (
        .i_req  (i_req),
        .i_fill (fill),
        .o_plan (plan),
        .o_at   (at)
    );

    isa_seq #(.CAPACITY(CAPACITY)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_plan  (plan),
        .i_at    (at),
        .i_value (i_req.value),
        .o_fill  (fill),
        .o_busy  (seq_busy),
        .o_fin   (fin),
        .o_rsp   (fin_rsp)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_rsp <= fin_rsp;
        end
    end

    assign busy   = seq_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

>>> design/isa_check.sv
module isa_check #(
    parameter int CAPACITY = 64
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input isa_pkg::t_req i_req,
    input logic          o_done,
    input isa_pkg::t_rsp o_rsp
);
    import isa_pkg::*;

    // A result only follows a taken word or a busy cycle
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result word without a request");

    // The end of a multi-cycle request shows its result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // Only a word-returning status carries a word
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != STAT_WORD)) |-> (o_rsp.word_out == '0))
        else $error("nonzero word on a status without word");

    // A refused add reports a full array
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == STAT_FULL)) |-> (o_rsp.held_count == CountW'(CAPACITY)))
        else $error("full status with count below capacity");

    // Requests are not taken while busy, so no result overlaps a new one
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !$past(busy) && $past(i_rst_n)) |-> !o_done)
        else $error("result while a request just started");

endmodule

bind indexed_shift_array isa_check #(.CAPACITY(CAPACITY)) u_isa_check (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import isa_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int RAND_WORDS = 1750;
    localparam int EPOCH_LEN  = 250;
    localparam int TAIL_WAIT  = 80;      // longest shift plus margin
    localparam int DRAIN_CAP  = 20000;

    // bias of the random request mix
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    // one row of the directed table
    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_done;
    t_rsp  o_rsp;

    logic [WordW-1:0] mirror_words[$];   // words the block should hold, index 0 first
    t_rsp             awaited_results[$];
    t_row             dir_rows[$];
    int               mismatch_count;

    indexed_shift_array #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // Apply one request to the mirrored array and return the result it gives
    function automatic t_rsp apply_request(input t_req r);
        t_rsp rsp;
        int   n;
        int   p;
        logic is_full;
        n = mirror_words.size();
        p = int'(r.position);
        is_full = (n >= CAPACITY);
        rsp.status = STAT_MISS;
        rsp.word_out = '0;
        case (r.opcode)
            OP_APPEND: begin
                if (is_full) begin
                    rsp.status = STAT_FULL;
                end else begin
                    mirror_words.push_back(r.value);
                    rsp.status = STAT_DONE;
                end
            end
            OP_PREPEND: begin
                if (is_full) begin
                    rsp.status = STAT_FULL;
                end else begin
                    mirror_words.push_front(r.value);
                    rsp.status = STAT_DONE;
                end
            end
            OP_POP_TAIL: begin
                if (n > 0) begin
                    rsp.word_out = mirror_words.pop_back();
                    rsp.status = STAT_WORD;
                end
            end
            OP_POP_HEAD: begin
                if (n > 0) begin
                    rsp.word_out = mirror_words.pop_front();
                    rsp.status = STAT_WORD;
                end
            end
            OP_INSERT: begin
                // range check wins over the full check
                if (p > n) begin
                    rsp.status = STAT_MISS;
                end else if (is_full) begin
                    rsp.status = STAT_FULL;
                end else begin
                    mirror_words.insert(p, r.value);
                    rsp.status = STAT_DONE;
                end
            end
            OP_REMOVE: begin
                if (p < n) begin
                    rsp.word_out = mirror_words[p];
                    mirror_words.delete(p);
                    rsp.status = STAT_WORD;
                end
            end
            OP_READ: begin
                if (p < n) begin
                    rsp.word_out = mirror_words[p];
                    rsp.status = STAT_WORD;
                end
            end
            OP_WRITE: begin
                if (p < n) begin
                    rsp.word_out = mirror_words[p];
                    mirror_words[p] = r.value;
                    rsp.status = STAT_WORD;
                end else if (p == n) begin
                    if (is_full) begin
                        rsp.status = STAT_FULL;
                    end else begin
                        mirror_words.push_back(r.value);
                        rsp.status = STAT_DONE;
                    end
                end
            end
            OP_CLEAR: begin
                mirror_words.delete();
                rsp.status = STAT_DONE;
            end
            default: begin
                rsp.status = STAT_MISS;
            end
        endcase
        rsp.held_count = CountW'(mirror_words.size());
        return rsp;
    endfunction

    // Directed row checked against the predictor
    function automatic t_row plan_row(input logic [OpW-1:0] op, input int pos,
                                      input logic [WordW-1:0] val);
        t_row row;
        row.req.opcode = op;
        row.req.position = PosW'(pos);
        row.req.value = val;
        row.fixed = 1'b0;
        row.rsp = '0;
        return row;
    endfunction

    // Directed row with the result typed in (word is zero for these)
    function automatic t_row fixed_row(input logic [OpW-1:0] op, input int pos,
                                       input logic [WordW-1:0] val, input t_status st,
                                       input int count);
        t_row row;
        row = plan_row(op, pos, val);
        row.fixed = 1'b1;
        row.rsp.status = st;
        row.rsp.word_out = '0;
        row.rsp.held_count = CountW'(count);
        return row;
    endfunction

    // Random request, positions mostly near the held words
    function automatic t_req pick_request(input t_mix mix);
        t_req r;
        int   n;
        int   roll;
        int   add_pct;
        int   take_pct;
        int   clear_pct;
        logic near;
        n = mirror_words.size();
        near = ($urandom_range(0, 99) < 85);
        r.position = PosW'($urandom_range(0, 127));
        if ($urandom_range(0, 9) == 0) begin
            r.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end else begin
            r.value = $urandom;
        end
        case (mix)
            MIX_GROW:   begin add_pct = 60; take_pct = 15; clear_pct = 0; end
            MIX_SHRINK: begin add_pct = 15; take_pct = 55; clear_pct = 2; end
            default:    begin add_pct = 35; take_pct = 30; clear_pct = 2; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            r.opcode = OpW'($urandom_range(9, 15));
        end else if (roll < 2 + clear_pct) begin
            r.opcode = OP_CLEAR;
        end else if (roll < 2 + clear_pct + add_pct) begin
            case ($urandom_range(0, 3))
                0: r.opcode = OP_APPEND;
                1: r.opcode = OP_PREPEND;
                2: begin
                    r.opcode = OP_INSERT;
                    if (near) r.position = PosW'($urandom_range(0, n));
                end
                default: begin
                    // write at the tail acts as append
                    r.opcode = OP_WRITE;
                    if (near) r.position = PosW'(n);
                end
            endcase
        end else if (roll < 2 + clear_pct + add_pct + take_pct) begin
            case ($urandom_range(0, 2))
                0: r.opcode = OP_POP_TAIL;
                1: r.opcode = OP_POP_HEAD;
                default: begin
                    r.opcode = OP_REMOVE;
                    if (near && n > 0) r.position = PosW'($urandom_range(0, n - 1));
                end
            endcase
        end else begin
            r.opcode = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            if (near && n > 0) r.position = PosW'($urandom_range(0, n - 1));
        end
        return r;
    endfunction

    // Hand one word to the block and log what it should answer
    task automatic send_word(input t_req req, input bit use_fixed, input t_rsp fixed_rsp,
                             input bit may_idle);
        t_rsp predicted;
        if (may_idle && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        predicted = apply_request(req);
        awaited_results.push_back(use_fixed ? fixed_rsp : predicted);
    endtask

    // Hold off until every pending result is back
    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (awaited_results.size() != 0 && waited < DRAIN_CAP);
    endtask

    // Result checker; the block cannot stall, so every strobe is a result
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: %p", o_rsp));
            end else begin
                want = awaited_results.pop_front();
                if (o_rsp.status !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d",
                                            o_rsp.status, want.status));
                if (o_rsp.word_out !== want.word_out)
                    note_mismatch($sformatf("word_out %08h, want %08h",
                                            o_rsp.word_out, want.word_out));
                if (o_rsp.held_count !== want.held_count)
                    note_mismatch($sformatf("held_count %0d, want %0d",
                                            o_rsp.held_count, want.held_count));
            end
        end
    end

    // Run limit
    initial begin
        #3ms;
        $display("testbench: done, errors");
        $finish;
    end

    // Stimulus
    initial begin
        t_mix mix;
        int   i;
        t_req req;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        mismatch_count = 0;

        // directed table: empty array first, then build, edit and tear down
        dir_rows.push_back(fixed_row(OP_POP_TAIL, 0, 32'h0, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(OP_POP_HEAD, 0, 32'h0, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(OP_READ, 0, 32'h0, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(OP_REMOVE, 0, 32'h0, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(OP_INSERT, 1, 32'h5, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(OP_WRITE, 1, 32'h5, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(4'hF, 127, 32'hFFFF_FFFF, STAT_MISS, 0));
        dir_rows.push_back(fixed_row(OP_APPEND, 127, 32'hFFFF_FFFF, STAT_DONE, 1));
        dir_rows.push_back(fixed_row(OP_PREPEND, 0, 32'h0, STAT_DONE, 2));
        dir_rows.push_back(fixed_row(OP_INSERT, 1, 32'hA5A5_A5A5, STAT_DONE, 3));
        dir_rows.push_back(fixed_row(OP_INSERT, 0, 32'h5A5A_5A5A, STAT_DONE, 4));
        dir_rows.push_back(fixed_row(OP_INSERT, 4, 32'h0000_0001, STAT_DONE, 5));
        dir_rows.push_back(fixed_row(OP_WRITE, 5, 32'h8000_0000, STAT_DONE, 6));
        dir_rows.push_back(plan_row(OP_WRITE, 2, 32'h1234_5678));
        dir_rows.push_back(plan_row(OP_READ, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(plan_row(OP_READ, 5, 32'h0));
        dir_rows.push_back(plan_row(OP_REMOVE, 1, 32'h0));
        dir_rows.push_back(plan_row(OP_POP_TAIL, 0, 32'h0));
        dir_rows.push_back(plan_row(OP_POP_HEAD, 0, 32'h0));
        dir_rows.push_back(fixed_row(OP_READ, 127, 32'h0, STAT_MISS, 3));
        dir_rows.push_back(fixed_row(OP_REMOVE, 3, 32'h0, STAT_MISS, 3));
        dir_rows.push_back(fixed_row(4'h9, 1, 32'h1, STAT_MISS, 3));
        dir_rows.push_back(fixed_row(OP_CLEAR, 64, 32'hFFFF_FFFF, STAT_DONE, 0));
        dir_rows.push_back(fixed_row(OP_READ, 0, 32'h0, STAT_MISS, 0));

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].rsp, 1'b1);

        // random part in epochs of changing bias, quiet at each boundary
        for (i = 0; i < RAND_WORDS; i++) begin
            if (i % EPOCH_LEN == 0) begin
                drain_results();
                case ((i / EPOCH_LEN) % 3)
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_SHRINK;
                    default: mix = MIX_EVEN;
                endcase
            end
            req = pick_request(mix);
            // back-to-back stretch with no sender gaps
            send_word(req, 1'b0, '0, !(i >= 700 && i < 1000));
        end

        // wind down
        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (awaited_results.size() != 0)
            note_mismatch($sformatf("%0d results never came", awaited_results.size()));
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
